@@ hdl/ssfp_pkg.sv @@
// shared types and constants for the servo status frame parser
package ssfp_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] LEN_BYTE   = 8'h13;
    localparam logic [7:0] ID_RESET   = 8'h01;

    // data byte index: frame byte number minus four
    localparam int         IDX_W       = 5;
    localparam logic [4:0] IDX_POS_LO  = 5'd1;
    localparam logic [4:0] IDX_POS_HI  = 5'd2;
    localparam logic [4:0] IDX_SPD_LO  = 5'd3;
    localparam logic [4:0] IDX_SPD_HI  = 5'd4;
    localparam logic [4:0] IDX_LOAD_LO = 5'd5;
    localparam logic [4:0] IDX_LOAD_HI = 5'd6;
    localparam logic [4:0] IDX_VOLT    = 5'd7;
    localparam logic [4:0] IDX_TEMP    = 5'd8;
    localparam logic [4:0] IDX_REGW    = 5'd9;
    localparam logic [4:0] IDX_MOVING  = 5'd11;
    localparam logic [4:0] IDX_TGT_LO  = 5'd12;
    localparam logic [4:0] IDX_TGT_HI  = 5'd13;
    localparam logic [4:0] IDX_CUR_LO  = 5'd14;
    localparam logic [4:0] IDX_CUR_HI  = 5'd15;
    localparam logic [4:0] IDX_LAST    = 5'd18;

    typedef enum logic [2:0] {
        ST_HUNT0,
        ST_HUNT1,
        ST_ID,
        ST_LEN,
        ST_DATA
    } t_front_state;

    typedef struct packed {
        logic [15:0] position;
        logic [15:0] speed;
        logic [15:0] load;
        logic [7:0]  voltage;
        logic [7:0]  temperature;
        logic [7:0]  reg_write_pending;
        logic [7:0]  moving;
        logic [15:0] target_position;
        logic [15:0] drive_current;
    } t_status;

    typedef struct packed {
        logic    ok;
        t_status status;
    } t_entry;

endpackage

@@ hdl/ssfp_front.sv @@
// front end: header hunt, checksum accumulation and field capture
module ssfp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    output logic                 o_push,
    output ssfp_pkg::t_entry     o_entry
);

    ssfp_pkg::t_front_state           r_state, n_state;
    logic [ssfp_pkg::IDX_W-1:0]       r_idx;
    logic [7:0]                       r_sum;
    logic [7:0]                       r_id;
    ssfp_pkg::t_status                r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= ssfp_pkg::ID_RESET;
        end else if (i_cfg_wr_en) begin
            r_id <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssfp_pkg::ST_HUNT0;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_valid) begin
            unique case (r_state)
                ssfp_pkg::ST_HUNT0: begin
                    n_state = (i_byte == ssfp_pkg::HDR_BYTE) ? ssfp_pkg::ST_HUNT1
                                                             : ssfp_pkg::ST_HUNT0;
                end
                ssfp_pkg::ST_HUNT1: begin
                    n_state = (i_byte == ssfp_pkg::HDR_BYTE) ? ssfp_pkg::ST_ID
                                                             : ssfp_pkg::ST_HUNT0;
                end
                ssfp_pkg::ST_ID: begin
                    n_state = (i_byte == r_id) ? ssfp_pkg::ST_LEN : ssfp_pkg::ST_HUNT0;
                end
                ssfp_pkg::ST_LEN: begin
                    n_state = ssfp_pkg::ST_DATA;
                end
                ssfp_pkg::ST_DATA: begin
                    n_state = (r_idx == ssfp_pkg::IDX_LAST) ? ssfp_pkg::ST_HUNT0
                                                            : ssfp_pkg::ST_DATA;
                end
                default: begin
                    n_state = ssfp_pkg::ST_HUNT0;
                end
            endcase
        end
    end

    always_comb begin
        o_push          = i_valid && (r_state == ssfp_pkg::ST_DATA)
                          && (r_idx == ssfp_pkg::IDX_LAST);
        o_entry.ok      = (~r_sum == i_byte);
        o_entry.status  = r_cap;
    end

    // sum and index carry no meaning while hunting, so they need no reset
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            unique case (r_state)
                ssfp_pkg::ST_ID: begin
                    r_sum <= i_byte;
                end
                ssfp_pkg::ST_LEN: begin
                    r_sum <= r_sum + ssfp_pkg::LEN_BYTE;
                    r_idx <= '0;
                end
                ssfp_pkg::ST_DATA: begin
                    r_sum <= r_sum + i_byte;
                    r_idx <= r_idx + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && (r_state == ssfp_pkg::ST_DATA)) begin
            unique case (r_idx)
                ssfp_pkg::IDX_POS_LO:  r_cap.position[7:0]         <= i_byte;
                ssfp_pkg::IDX_POS_HI:  r_cap.position[15:8]        <= i_byte;
                ssfp_pkg::IDX_SPD_LO:  r_cap.speed[7:0]            <= i_byte;
                ssfp_pkg::IDX_SPD_HI:  r_cap.speed[15:8]           <= i_byte;
                ssfp_pkg::IDX_LOAD_LO: r_cap.load[7:0]             <= i_byte;
                ssfp_pkg::IDX_LOAD_HI: r_cap.load[15:8]            <= i_byte;
                ssfp_pkg::IDX_VOLT:    r_cap.voltage               <= i_byte;
                ssfp_pkg::IDX_TEMP:    r_cap.temperature           <= i_byte;
                ssfp_pkg::IDX_REGW:    r_cap.reg_write_pending     <= i_byte;
                ssfp_pkg::IDX_MOVING:  r_cap.moving                <= i_byte;
                ssfp_pkg::IDX_TGT_LO:  r_cap.target_position[7:0]  <= i_byte;
                ssfp_pkg::IDX_TGT_HI:  r_cap.target_position[15:8] <= i_byte;
                ssfp_pkg::IDX_CUR_LO:  r_cap.drive_current[7:0]    <= i_byte;
                ssfp_pkg::IDX_CUR_HI:  r_cap.drive_current[15:8]   <= i_byte;
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hdl/ssfp_fifo.sv @@
// small queue of completed frames between front and back
module ssfp_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ssfp_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output ssfp_pkg::t_entry     o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssfp_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_entry   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/ssfp_back.sv @@
// back end: held status update and result register
module ssfp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ssfp_pkg::t_entry     i_entry,
    output logic                 o_take,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic                 o_frame_ok,
    output ssfp_pkg::t_status    o_status
);

    ssfp_pkg::t_status  r_held;
    logic               r_out_valid;
    logic               r_out_ok;
    ssfp_pkg::t_status  r_out_status;

    // result register refills in the same cycle it is popped
    assign o_take     = i_valid && (!r_out_valid || i_pop);
    assign o_empty    = !r_out_valid;
    assign o_frame_ok = r_out_ok;
    assign o_status   = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_out_valid <= 1'b1;
                if (i_entry.ok) begin
                    r_held <= i_entry.status;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_ok     <= i_entry.ok;
            r_out_status <= i_entry.ok ? i_entry.status : r_held;
        end
    end

endmodule

@@ hdl/servo_status_frame_parser.sv @@
// top level of the servo status frame parser
// a finished frame passes through the frame queue, then the result register, before its result shows
// throughput: one byte per cycle; the front stalls only when the frame queue is full
// frame queue depth QUEUE_DEPTH sets how many finished frames wait on a stalled reader
// reset: synchronous, active low; hunting for a header, queue and result empty,
// held status zero, servo id 1
module servo_status_frame_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_rx_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_frame_ok,
    output logic [15:0] o_position,
    output logic [15:0] o_speed,
    output logic [15:0] o_load,
    output logic [7:0]  o_voltage,
    output logic [7:0]  o_temperature,
    output logic [7:0]  o_reg_write_pending,
    output logic [7:0]  o_moving,
    output logic [15:0] o_target_position,
    output logic [15:0] o_drive_current
);

    logic               w_accept;
    logic               w_q_push;
    logic               w_q_full;
    logic               w_q_empty;
    logic               w_q_take;
    ssfp_pkg::t_entry   w_front_entry;
    ssfp_pkg::t_entry   w_q_entry;
    ssfp_pkg::t_status  w_status;

    assign o_full   = w_q_full;
    assign w_accept = i_push && !w_q_full;

    ssfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (w_accept),
        .i_byte       (i_rx_byte),
        .o_push       (w_q_push),
        .o_entry      (w_front_entry)
    );

    ssfp_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_entry(w_front_entry),
        .i_pop  (w_q_take),
        .o_full (w_q_full),
        .o_empty(w_q_empty),
        .o_entry(w_q_entry)
    );

    ssfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!w_q_empty),
        .i_entry   (w_q_entry),
        .o_take    (w_q_take),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_frame_ok(o_frame_ok),
        .o_status  (w_status)
    );

    assign o_position          = w_status.position;
    assign o_speed             = w_status.speed;
    assign o_load              = w_status.load;
    assign o_voltage           = w_status.voltage;
    assign o_temperature       = w_status.temperature;
    assign o_reg_write_pending = w_status.reg_write_pending;
    assign o_moving            = w_status.moving;
    assign o_target_position   = w_status.target_position;
    assign o_drive_current     = w_status.drive_current;

    // a finished frame never meets a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("frame queue overflow");

    // back end only drains a queue that holds something
    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_take |-> !w_q_empty)
        else $error("take from empty frame queue");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    // a bad frame repeats the status of the result before it
    a_bad_keeps_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty) ##1 (!o_empty && !o_frame_ok)
        |-> (o_position == $past(o_position) && o_drive_current == $past(o_drive_current)))
        else $error("status changed on checksum mismatch");

endmodule

@@ sim/servo_status_frame_parser_test.sv @@
// self-checking testbench for the servo status frame parser
`timescale 1ns / 100ps

module servo_status_frame_parser_test;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_BYTES = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 50;

    // parser phases: frame byte number that comes next
    localparam logic [4:0] PH_HUNT0 = 5'd0;
    localparam logic [4:0] PH_HUNT1 = 5'd1;
    localparam logic [4:0] PH_ID    = 5'd2;
    localparam logic [4:0] PH_LEN   = 5'd3;
    localparam logic [4:0] PH_DATA0 = 5'd4;
    localparam logic [4:0] PH_LAST  = 5'd22;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        i_push;
    logic        o_full;
    logic [7:0]  i_rx_byte;
    logic        o_empty;
    logic        i_pop;
    logic        o_frame_ok;
    logic [15:0] o_position;
    logic [15:0] o_speed;
    logic [15:0] o_load;
    logic [7:0]  o_voltage;
    logic [7:0]  o_temperature;
    logic [7:0]  o_reg_write_pending;
    logic [7:0]  o_moving;
    logic [15:0] o_target_position;
    logic [15:0] o_drive_current;

    servo_status_frame_parser dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_push              (i_push),
        .o_full              (o_full),
        .i_rx_byte           (i_rx_byte),
        .o_empty             (o_empty),
        .i_pop               (i_pop),
        .o_frame_ok          (o_frame_ok),
        .o_position          (o_position),
        .o_speed             (o_speed),
        .o_load              (o_load),
        .o_voltage           (o_voltage),
        .o_temperature       (o_temperature),
        .o_reg_write_pending (o_reg_write_pending),
        .o_moving            (o_moving),
        .o_target_position   (o_target_position),
        .o_drive_current     (o_drive_current)
    );

    // frame parser mirror
    logic [7:0]         servo_id;
    logic [4:0]         parse_phase;
    logic [7:0]         parse_sum;
    logic [7:0]         frame_data [0:18];
    ssfp_pkg::t_status  held_status;
    ssfp_pkg::t_entry   expected_frames [$];

    logic [7:0]  frame_buf [0:22];
    bit          steady_flow;
    bit          hold_off_req;
    int          pop_stall_left;
    int          cycle_count;
    int          mismatches;
    int          bytes_sent;
    int          full_stalls;
    int          hold_offs;
    int          results_seen;
    int          results_ok;
    int          id_writes;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // advance the parser mirror by one accepted byte
    task automatic parse_byte(input logic [7:0] b);
        ssfp_pkg::t_entry entry;
        bit               sum_ok;
        case (parse_phase)
            PH_HUNT0: parse_phase = (b == ssfp_pkg::HDR_BYTE) ? PH_HUNT1 : PH_HUNT0;
            PH_HUNT1: parse_phase = (b == ssfp_pkg::HDR_BYTE) ? PH_ID : PH_HUNT0;
            PH_ID: begin
                if (b == servo_id) begin
                    parse_sum   = b;
                    parse_phase = PH_LEN;
                end else begin
                    parse_phase = PH_HUNT0;
                end
            end
            PH_LEN: begin
                // length byte always counts as the fixed status length
                parse_sum   = parse_sum + ssfp_pkg::LEN_BYTE;
                parse_phase = PH_DATA0;
            end
            default: begin
                frame_data[parse_phase - PH_DATA0] = b;
                if (parse_phase < PH_LAST) begin
                    parse_sum   = parse_sum + b;
                    parse_phase = parse_phase + 5'd1;
                end else begin
                    sum_ok = ((parse_sum ^ 8'hFF) == b);
                    if (sum_ok) begin
                        held_status.position          = {frame_data[ssfp_pkg::IDX_POS_HI],
                                                         frame_data[ssfp_pkg::IDX_POS_LO]};
                        held_status.speed             = {frame_data[ssfp_pkg::IDX_SPD_HI],
                                                         frame_data[ssfp_pkg::IDX_SPD_LO]};
                        held_status.load              = {frame_data[ssfp_pkg::IDX_LOAD_HI],
                                                         frame_data[ssfp_pkg::IDX_LOAD_LO]};
                        held_status.voltage           = frame_data[ssfp_pkg::IDX_VOLT];
                        held_status.temperature       = frame_data[ssfp_pkg::IDX_TEMP];
                        held_status.reg_write_pending = frame_data[ssfp_pkg::IDX_REGW];
                        held_status.moving            = frame_data[ssfp_pkg::IDX_MOVING];
                        held_status.target_position   = {frame_data[ssfp_pkg::IDX_TGT_HI],
                                                         frame_data[ssfp_pkg::IDX_TGT_LO]};
                        held_status.drive_current     = {frame_data[ssfp_pkg::IDX_CUR_HI],
                                                         frame_data[ssfp_pkg::IDX_CUR_LO]};
                    end
                    parse_phase  = PH_HUNT0;
                    parse_sum    = 8'h00;
                    entry.ok     = sum_ok;
                    entry.status = held_status;
                    expected_frames.push_back(entry);
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        i_push    <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        parse_byte(b);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_push    <= 1'b0;
            i_rx_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic build_frame(input logic [7:0] id, input bit good_sum, input int fill);
        logic [7:0] sum;
        frame_buf[0] = ssfp_pkg::HDR_BYTE;
        frame_buf[1] = ssfp_pkg::HDR_BYTE;
        frame_buf[2] = id;
        frame_buf[3] = 8'($urandom);
        sum = id + ssfp_pkg::LEN_BYTE;
        for (int k = 4; k < 22; k++) begin
            case (fill)
                FILL_ZERO: frame_buf[k] = 8'h00;
                FILL_ONES: frame_buf[k] = 8'hFF;
                default:   frame_buf[k] = 8'($urandom);
            endcase
            sum = sum + frame_buf[k];
        end
        frame_buf[22] = sum ^ 8'hFF;
        if (!good_sum)
            frame_buf[22] = frame_buf[22] ^ 8'($urandom_range(1, 255));
    endtask

    task automatic send_frame_bytes(input int first, input int last);
        for (int k = first; k <= last; k++)
            send_byte(frame_buf[k]);
    endtask

    task automatic send_frame(input logic [7:0] id, input bit good_sum, input int fill);
        build_frame(id, good_sum, fill);
        send_frame_bytes(0, 22);
    endtask

    // stop offering and wait until every expected status has come out
    task automatic drain();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge i_clk);
        // bytes that give no status may still be in flight
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_servo_id(input logic [7:0] id);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= id;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'($urandom);
        servo_id = id;
        id_writes++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // result side: compare every popped status with the oldest prediction
    always @(posedge i_clk) begin : check_result
        ssfp_pkg::t_entry want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: status item with none expected, expected none actual ok=%b",
                             $time, o_frame_ok);
            end else begin
                want = expected_frames.pop_front();
                results_seen++;
                if (want.ok)
                    results_ok++;
                check_field("frame_ok", 16'(want.ok), 16'(o_frame_ok));
                check_field("position", want.status.position, o_position);
                check_field("speed", want.status.speed, o_speed);
                check_field("load", want.status.load, o_load);
                check_field("voltage", 16'(want.status.voltage), 16'(o_voltage));
                check_field("temperature", 16'(want.status.temperature),
                            16'(o_temperature));
                check_field("reg_write_pending", 16'(want.status.reg_write_pending),
                            16'(o_reg_write_pending));
                check_field("moving", 16'(want.status.moving), 16'(o_moving));
                check_field("target_position", want.status.target_position,
                            o_target_position);
                check_field("drive_current", want.status.drive_current,
                            o_drive_current);
            end
        end
    end

    // reader: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin : reader
        int g;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (pop_stall_left > 0) begin
            i_pop <= 1'b0;
            pop_stall_left--;
        end else if (hold_off_req) begin
            hold_off_req   = 1'b0;
            pop_stall_left = HOLD_CYCLES - 1;
            hold_offs++;
            i_pop <= 1'b0;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                i_pop <= 1'b1;
            end else begin
                i_pop <= 1'b0;
                pop_stall_left = g - 1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("servo_status_frame_parser_test: done, errors");
        $finish;
    end

    task automatic test_status_extremes();
        send_frame(servo_id, 1'b1, FILL_ZERO);
        send_frame(servo_id, 1'b1, FILL_ONES);
        // bad checksum keeps the all-ones status
        send_frame(servo_id, 1'b0, FILL_RANDOM);
        send_frame(servo_id, 1'b1, FILL_RANDOM);
        send_frame(servo_id, 1'b0, FILL_ZERO);
    endtask

    task automatic test_header_breaks();
        send_byte(ssfp_pkg::HDR_BYTE);
        send_byte(8'h00);
        send_byte(ssfp_pkg::HDR_BYTE);
        send_byte(ssfp_pkg::HDR_BYTE);
        send_byte(servo_id ^ 8'h01);
        // after a failed id byte the parser hunts for a new header
        send_byte(ssfp_pkg::HDR_BYTE);
        send_byte(ssfp_pkg::HDR_BYTE);
        send_frame(servo_id, 1'b1, FILL_RANDOM);
        repeat (4) send_byte(8'h00);
        send_frame(servo_id, 1'b1, FILL_RANDOM);
        drain();
    endtask

    task automatic test_id_settings();
        logic [7:0] ids [0:4];
        ids[0] = 8'h00;
        ids[1] = 8'd253;
        ids[2] = 8'hFE;
        ids[3] = 8'hFF;
        ids[4] = 8'($urandom_range(2, 252));
        for (int k = 0; k < 5; k++) begin
            set_servo_id(ids[k]);
            send_frame(servo_id, 1'b1, FILL_RANDOM);
            send_frame(servo_id ^ 8'h01, 1'b1, FILL_RANDOM);
            send_frame(servo_id, 1'b0, FILL_RANDOM);
            send_frame(servo_id, 1'b1, FILL_RANDOM);
        end
        set_servo_id(ssfp_pkg::ID_RESET);
    endtask

    task automatic test_id_write_mid_frame();
        build_frame(servo_id, 1'b1, FILL_RANDOM);
        send_frame_bytes(0, 9);
        // new id only applies to later headers
        set_servo_id(servo_id ^ 8'h5A);
        send_frame_bytes(10, 22);
        send_frame(servo_id, 1'b1, FILL_RANDOM);
        drain();
    endtask

    task automatic test_receiver_hold_off();
        steady_flow  = 1'b1;
        hold_off_req = 1'b1;
        repeat (12) send_frame(servo_id, 1'b1, FILL_RANDOM);
        steady_flow = 1'b0;
        drain();
    endtask

    task automatic test_random_traffic();
        int         frame_bytes;
        int         r;
        int         cut;
        logic [7:0] id;
        frame_bytes = 0;
        while (frame_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 29) == 0) begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    id = 8'h00;
                else if (r < 20)
                    id = 8'd253;
                else if (r < 25)
                    id = 8'hFE;
                else if (r < 30)
                    id = 8'hFF;
                else
                    id = 8'($urandom);
                set_servo_id(id);
            end
            if ($urandom_range(0, 9) == 0)
                steady_flow = !steady_flow;
            r = $urandom_range(0, 99);
            if (r < 60) begin
                cut = $urandom_range(0, 19);
                send_frame(servo_id, 1'b1,
                           (cut == 0) ? FILL_ZERO : (cut == 1) ? FILL_ONES : FILL_RANDOM);
                frame_bytes += 23;
            end else if (r < 72) begin
                send_frame(servo_id, 1'b0, FILL_RANDOM);
                frame_bytes += 23;
            end else if (r < 80) begin
                send_frame(servo_id ^ 8'($urandom_range(1, 255)), 1'b1, FILL_RANDOM);
                frame_bytes += 23;
            end else if (r < 90) begin
                cut = $urandom_range(0, 21);
                build_frame(servo_id, 1'b1, FILL_RANDOM);
                send_frame_bytes(0, cut);
                frame_bytes += cut + 1;
            end else begin
                // line noise, heavy on header bytes
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 1) == 0) ? ssfp_pkg::HDR_BYTE
                                                          : 8'($urandom));
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = 8'h00;
        i_push         = 1'b0;
        i_rx_byte      = 8'h00;
        i_pop          = 1'b0;
        steady_flow    = 1'b0;
        hold_off_req   = 1'b0;
        pop_stall_left = 0;
        mismatches     = 0;
        bytes_sent     = 0;
        full_stalls    = 0;
        hold_offs      = 0;
        results_seen   = 0;
        results_ok     = 0;
        id_writes      = 0;
        servo_id       = ssfp_pkg::ID_RESET;
        parse_phase    = PH_HUNT0;
        parse_sum      = 8'h00;
        held_status    = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_status_extremes();
        test_header_breaks();
        test_id_settings();
        test_id_write_mid_frame();
        test_receiver_hold_off();
        test_random_traffic();

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d rx bytes, %0d status items (%0d with good checksum)",
                 bytes_sent, results_seen, results_ok);
        $display("%0d servo id writes, %0d input stall cycles, %0d long reader hold-offs",
                 id_writes, full_stalls, hold_offs);
        if (mismatches == 0)
            $display("servo_status_frame_parser_test: done, clean");
        else
            $display("servo_status_frame_parser_test: done, errors");
        $finish;
    end

endmodule
